// ----- hw/rtl/ddo_pkg.sv -----
`timescale 1ns / 1ps
package ddo_pkg;

  // cordic configuration
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  // shared multiplier widths
  localparam int A_W    = 41;
  localparam int B_W    = 32;
  localparam int PROD_W = A_W + 17;
  localparam int ACC_W  = 66;

  // register reset values
  localparam logic [23:0] DIST_PER_TICK_RST  = 24'd10304;
  localparam logic [23:0] TURN_PER_TICK_RST  = 24'd1825418;
  localparam logic [15:0] UPDATE_RATE_RST    = 16'd10;

  typedef enum logic [1:0] {
    CFG_DIST_PER_TICK = 2'd0,
    CFG_TURN_PER_TICK = 2'd1,
    CFG_UPDATE_RATE   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_ROT  = 3'd2,
    S_POST = 3'd3,
    S_OUT  = 3'd4
  } state_t;

  // products in the order the sequencer runs them
  typedef enum logic [2:0] {
    OP_DIST  = 3'd0,
    OP_TURN  = 3'd1,
    OP_LIN   = 3'd2,
    OP_ANG   = 3'd3,
    OP_XSTEP = 3'd4,
    OP_YSTEP = 3'd5,
    OP_XSPD  = 3'd6,
    OP_YSPD  = 3'd7
  } op_t;

  typedef struct packed {
    logic en;
    logic hi_pass;
  } ddo_mac_ctl_t;

  // arctangent per step, 2^32 per turn
  function automatic logic signed [31:0] atan_turn32(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10680862;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/ddo_in_if.sv -----
`timescale 1ns / 1ps
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_delta;
  logic signed [15:0] right_delta;

  modport source (output valid, output left_delta, output right_delta, input ready);
  modport sink (input valid, input left_delta, input right_delta, output ready);
endinterface

// ----- hw/rtl/ddo_out_if.sv -----
`timescale 1ns / 1ps
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic        [15:0] heading_angle;
  logic signed [31:0] linear_speed;
  logic signed [31:0] x_speed;
  logic signed [31:0] y_speed;
  logic signed [31:0] turn_speed;

  modport source (
    output valid, output x_position, output y_position, output heading_angle,
    output linear_speed, output x_speed, output y_speed, output turn_speed,
    input ready
  );
  modport sink (
    input valid, input x_position, input y_position, input heading_angle,
    input linear_speed, input x_speed, input y_speed, input turn_speed,
    output ready
  );
endinterface

// ----- hw/rtl/ddo_cfg_if.sv -----
`timescale 1ns / 1ps
interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ddo_mac.sv -----
`timescale 1ns / 1ps
module ddo_mac import ddo_pkg::*; (
  input  logic                    clk,
  input  ddo_mac_ctl_t            ctl,
  input  logic signed [A_W-1:0]   op_a,
  input  logic signed [B_W-1:0]   op_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [16:0]       b_part;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  // upper half signed first, lower half unsigned second
  assign b_part = ctl.hi_pass ? {op_b[B_W-1], op_b[B_W-1:16]} : {1'b0, op_b[15:0]};
  assign prod   = op_a * b_part;

  always_comb begin
    if (ctl.hi_pass) begin
      acc_nxt = ACC_W'(prod);
    end else begin
      acc_nxt = (acc_r <<< 16) + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- hw/rtl/ddo_cordic.sv -----
`timescale 1ns / 1ps
module ddo_cordic import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  logic              busy_r;
  logic [ITER_W-1:0] cnt_r;
  logic [1:0]        quad_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [31:0] x_nxt, y_nxt, z_nxt;
  logic signed [31:0] cos_r, sin_r;
  logic signed [31:0] cos_nxt, sin_nxt;
  logic signed [31:0] dx, dy, atan_v;
  logic [31:0]        a_masked, a_bias, z_init;
  logic [1:0]         quad;
  logic               last;

  // fold by quarter turns into [-1/8, 1/8) turn
  assign a_masked = angle & ANGLE_MASK;
  assign a_bias   = a_masked + 32'h2000_0000;
  assign quad     = a_bias[31:30];
  assign z_init   = a_masked - {quad, 30'd0};

  assign dx     = x_r >>> cnt_r;
  assign dy     = y_r >>> cnt_r;
  assign atan_v = atan_turn32(5'(cnt_r));
  assign last   = (cnt_r == ITER_W'(CORDIC_ITERS - 1));
  assign done   = busy_r && last;

  always_comb begin
    if (!z_r[31]) begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + atan_v;
    end
  end

  // unfold the quadrant
  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_nxt = x_nxt;
        sin_nxt = y_nxt;
      end
      2'd1: begin
        cos_nxt = -y_nxt;
        sin_nxt = x_nxt;
      end
      2'd2: begin
        cos_nxt = -x_nxt;
        sin_nxt = -y_nxt;
      end
      default: begin
        cos_nxt = y_nxt;
        sin_nxt = -x_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + ITER_W'(1);
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= GAIN_Q30;
      y_r    <= '0;
      z_r    <= z_init;
      quad_r <= quad;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    if (done) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule

// ----- hw/rtl/diff_drive_odometry.sv -----
`timescale 1ns / 1ps
// sequence from request accept to result valid: four products, the cordic run
// (16 iterations, one step per cycle), four more products, the post state and
// an output load that waits for a free output register; a new request is taken
// only back in idle; the shared multiplier is 41x17, two passes per product
// reset: synchronous active-low rst_n zeroes the pose and heading, loads the
// default registers and empties the output register
module diff_drive_odometry import ddo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ddo_in_if.sink     in_req,
  ddo_out_if.source  out_res,
  ddo_cfg_if.sink    cfg_wr
);

  // sequencer
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   pass_r, pass_nxt;       // 0: upper half of b, 1: lower half
  logic   post_vld_r;             // accumulator holds a finished product
  op_t    post_op_r;

  // configuration
  logic [23:0] dist_per_tick_r;
  logic [23:0] turn_per_tick_r;
  logic [15:0] update_rate_r;

  // pose state
  logic [31:0] pos_x_r, pos_y_r, head_r;
  logic [31:0] head_nxt;

  // captured request and intermediate results
  logic signed [15:0] left_r, right_r;
  logic signed [33:0] dist_r;     // travelled distance, Q18.16
  logic signed [40:0] dth_r;      // heading change, heading lsbs
  logic signed [31:0] v_r, w_r, vx_r, vy_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] x_out_r, y_out_r, lin_out_r, xs_out_r, ys_out_r, turn_out_r;
  logic [15:0]        head_out_r;

  // datapath signals
  logic signed [16:0]      sum_lr, diff_lr;
  logic signed [A_W-1:0]   mac_a;
  logic signed [B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0] acc;
  ddo_mac_ctl_t            mac_ctl;
  logic                    cor_start, cor_done;
  logic signed [31:0]      cos_q30, sin_q30;
  logic                    in_take, out_load, out_free;

  logic signed [ACC_W-1:0] post_rnd, post_sum, post_shf;
  logic [ACC_W-32:0]       post_hi;
  logic signed [31:0]      post_sat;

  assign in_take  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign cfg_wr.ready = (state_r == S_IDLE);

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (pass_r && op_r == OP_ANG) begin
          state_nxt = S_ROT;
        end else if (pass_r && op_r == OP_YSPD) begin
          state_nxt = S_POST;
        end
      end
      S_ROT: begin
        if (cor_done) state_nxt = S_MUL;
      end
      S_POST: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_req.ready    = 1'b0;
    mac_ctl.en      = 1'b0;
    mac_ctl.hi_pass = !pass_r;
    cor_start       = 1'b0;
    out_load        = 1'b0;
    op_nxt          = op_r;
    pass_nxt        = pass_r;
    unique case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        op_nxt       = OP_DIST;
        pass_nxt     = 1'b0;
      end
      S_MUL: begin
        mac_ctl.en = 1'b1;
        pass_nxt   = !pass_r;
        if (pass_r) begin
          op_nxt = op_t'(op_r + 3'd1);
        end
        // cordic takes the old heading once the heading change is in
        cor_start = pass_r && (op_r == OP_ANG);
      end
      S_ROT: ;
      S_POST: ;
      S_OUT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      op_r       <= OP_DIST;
      pass_r     <= 1'b0;
      post_vld_r <= 1'b0;
      post_op_r  <= OP_DIST;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      pass_r     <= pass_nxt;
      post_vld_r <= (state_r == S_MUL) && pass_r;
      post_op_r  <= op_r;
    end
  end

  // ---------------------------------------------------------------------
  // configuration writes, only while idle
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_per_tick_r <= DIST_PER_TICK_RST;
      turn_per_tick_r <= TURN_PER_TICK_RST;
      update_rate_r   <= UPDATE_RATE_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        CFG_DIST_PER_TICK: dist_per_tick_r <= cfg_wr.data;
        CFG_TURN_PER_TICK: turn_per_tick_r <= cfg_wr.data;
        CFG_UPDATE_RATE:   update_rate_r   <= cfg_wr.data[15:0];
        default: ;         // unknown index is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // request capture
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      left_r  <= in_req.left_delta;
      right_r <= in_req.right_delta;
    end
  end

  assign sum_lr  = 17'(left_r) + 17'(right_r);
  assign diff_lr = 17'(left_r) - 17'(right_r);

  // ---------------------------------------------------------------------
  // operand select for the shared multiplier
  // ---------------------------------------------------------------------
  always_comb begin
    case (op_r)
      OP_DIST: begin
        mac_a = A_W'(sum_lr);
        mac_b = B_W'({8'd0, dist_per_tick_r});
      end
      OP_TURN: begin
        mac_a = A_W'(diff_lr);
        mac_b = B_W'({8'd0, turn_per_tick_r});
      end
      OP_LIN: begin
        mac_a = A_W'(dist_r);
        mac_b = B_W'({16'd0, update_rate_r});
      end
      OP_ANG: begin
        mac_a = dth_r;
        mac_b = B_W'({16'd0, update_rate_r});
      end
      OP_XSTEP: begin
        mac_a = A_W'(dist_r);
        mac_b = cos_q30;
      end
      OP_YSTEP: begin
        mac_a = A_W'(dist_r);
        mac_b = sin_q30;
      end
      OP_XSPD: begin
        mac_a = A_W'(v_r);
        mac_b = cos_q30;
      end
      default: begin
        mac_a = A_W'(v_r);
        mac_b = sin_q30;
      end
    endcase
  end

  ddo_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (head_r),
    .done    (cor_done),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  // ---------------------------------------------------------------------
  // post-processing of a finished product: round, shift, saturate
  // runs in the cycle after the product's lower pass
  // ---------------------------------------------------------------------
  always_comb begin
    case (post_op_r) inside
      OP_DIST:                              post_rnd = ACC_W'(256);
      OP_XSTEP, OP_YSTEP, OP_XSPD, OP_YSPD: post_rnd = ACC_W'(32'h2000_0000);
      default:                              post_rnd = '0;
    endcase
  end

  assign post_sum = acc + post_rnd;

  always_comb begin
    case (post_op_r) inside
      OP_DIST:                              post_shf = post_sum >>> 9;
      OP_XSTEP, OP_YSTEP, OP_XSPD, OP_YSPD: post_shf = post_sum >>> 30;
      default:                              post_shf = post_sum;
    endcase
  end

  // saturate to the signed 32-bit range
  assign post_hi = post_shf[ACC_W-1:31];
  always_comb begin
    if ((&post_hi) || !(|post_hi)) begin
      post_sat = post_shf[31:0];
    end else if (post_shf[ACC_W-1]) begin
      post_sat = 32'sh8000_0000;
    end else begin
      post_sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (post_vld_r) begin
      case (post_op_r)
        OP_DIST:  dist_r <= post_shf[33:0];
        OP_TURN:  dth_r  <= acc[40:0];
        OP_LIN:   v_r    <= post_sat;
        OP_ANG:   w_r    <= post_sat;
        OP_XSPD:  vx_r   <= post_sat;
        OP_YSPD:  vy_r   <= post_sat;
        default: ;
      endcase
    end
  end

  // pose: positions wrap, heading wraps
  assign head_nxt = head_r + dth_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      head_r  <= '0;
    end else begin
      if (post_vld_r && post_op_r == OP_XSTEP) begin
        pos_x_r <= pos_x_r + post_shf[31:0];
      end
      if (post_vld_r && post_op_r == OP_YSTEP) begin
        pos_y_r <= pos_y_r + post_shf[31:0];
      end
      if (out_load) begin
        head_r <= head_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      x_out_r    <= pos_x_r;
      y_out_r    <= pos_y_r;
      head_out_r <= head_nxt[31:16];
      lin_out_r  <= v_r;
      xs_out_r   <= vx_r;
      ys_out_r   <= vy_r;
      turn_out_r <= w_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.x_position    = x_out_r;
  assign out_res.y_position    = y_out_r;
  assign out_res.heading_angle = head_out_r;
  assign out_res.linear_speed  = lin_out_r;
  assign out_res.x_speed       = xs_out_r;
  assign out_res.y_speed       = ys_out_r;
  assign out_res.turn_speed    = turn_out_r;

endmodule
